FILE: sv/icsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsb_pkg
// Shared types and constants of the icon shadow disabled blend core.
// ----------------------------------------------------------------------------
package icsb_pkg;

  // Line store depth, the widest row in pixels.
  localparam int MAX_WIDTH = 32;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = $clog2(MAX_WIDTH + 1);

  localparam logic [7:0]  ALPHA_MAX      = 8'hFF;
  localparam logic [5:0]  ROW_WIDTH_RST  = 6'd16;
  localparam logic [23:0] TEXT_COLOR_RST = 24'h000000;
  localparam logic [23:0] FILL_COLOR_RST = 24'hAAAAAA;
  localparam logic [23:0] EDGE_COLOR_RST = 24'hFFFFFF;

  // Register indexes; register i lies at byte address 4*i.
  typedef enum logic [1:0] {
    REG_ROW_WIDTH,
    REG_TEXT_COLOR,
    REG_FILL_COLOR,
    REG_EDGE_COLOR
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] alpha_in;
    logic       start_of_image;
  } alpha_req_t;

  typedef struct packed {
    logic [31:0] normal_pixel;
    logic [31:0] disabled_pixel;
  } pixel_req_t;

  // One pixel after the line store: its alpha and its shadow alpha.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] shadow;
  } raster_item_t;

  typedef struct packed {
    logic [23:0] text_color;
    logic [23:0] fill_color;
    logic [23:0] edge_color;
  } color_cfg_t;

endpackage
`default_nettype wire

FILE: sv/icsb_raster.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsb_raster
// Raster position tracking and previous-row line store; yields the shadow
// alpha of each pixel, taken from the pixel one row up and one column left.
// ----------------------------------------------------------------------------
module icsb_raster (
  input  wire                       clk,
  input  wire                       rst,
  input  wire  [5:0]                row_width,
  input  wire                       alpha_valid,
  output logic                      alpha_ready,
  input  wire  icsb_pkg::alpha_req_t alpha_req,
  output logic                      item_valid,
  input  wire                       item_ready,
  output icsb_pkg::raster_item_t    item
);
  import icsb_pkg::*;

  logic [7:0]       line_mem [MAX_WIDTH];
  logic [CNT_W-1:0] column_count;
  logic             below_first_row;
  logic [7:0]       corner_alpha;

  logic [CNT_W-1:0] width_eff;
  logic [CNT_W-1:0] col_base;
  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] col_inc;
  logic             below_eff;
  logic             row_end;
  logic [7:0]       shadow;
  logic             accept;

  assign alpha_ready = !item_valid || item_ready;
  assign accept      = alpha_valid && alpha_ready;

  always_comb begin
    if (row_width == '0) begin
      width_eff = CNT_W'(1);
    end else if (32'(row_width) > MAX_WIDTH) begin
      width_eff = CNT_W'(MAX_WIDTH);
    end else begin
      width_eff = CNT_W'(row_width);
    end
    col_base  = alpha_req.start_of_image ? '0 : column_count;
    below_eff = alpha_req.start_of_image ? 1'b0 : below_first_row;
    col       = (32'(col_base) >= MAX_WIDTH) ? '0 : col_base;
    col_inc   = col + CNT_W'(1);
    row_end   = col_inc >= width_eff;
    shadow    = (col != '0 && below_eff) ? corner_alpha : 8'd0;
  end

  // Read before write at the same column: the registered read holds the
  // previous row's alpha, which becomes the next pixel's corner.
  always_ff @(posedge clk) begin
    if (accept) begin
      corner_alpha <= line_mem[col[COL_W-1:0]];
      line_mem[col[COL_W-1:0]] <= alpha_req.alpha_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      below_first_row <= 1'b0;
      item_valid      <= 1'b0;
    end else begin
      if (accept) begin
        if (row_end) begin
          column_count    <= '0;
          below_first_row <= 1'b1;
        end else begin
          column_count    <= col_inc;
          below_first_row <= below_eff;
        end
      end
      if (alpha_ready) begin
        item_valid <= alpha_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.alpha  <= alpha_req.alpha_in;
      item.shadow <= shadow;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(column_count) < MAX_WIDTH)
    else $error("column count left the row");

  a_start_resets: assert property (@(posedge clk) disable iff (rst)
    accept && alpha_req.start_of_image |=>
      column_count <= CNT_W'(1) && below_first_row == (column_count == '0))
    else $error("start of image did not restart the raster");

  a_first_col_shadow: assert property (@(posedge clk) disable iff (rst)
    accept && col == '0 |=> item.shadow == 8'd0)
    else $error("shadow on the first column");

endmodule
`default_nettype wire

FILE: sv/icsb_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsb_blend
// Two-stage blend: products of alpha and color channels, then sums scaled
// down by 256 into the normal and disabled ARGB pixels.
// ----------------------------------------------------------------------------
module icsb_blend (
  input  wire                         clk,
  input  wire                         rst,
  input  wire  icsb_pkg::color_cfg_t  colors,
  input  wire                         item_valid,
  output logic                        item_ready,
  input  wire  icsb_pkg::raster_item_t item,
  output logic                        pixel_valid,
  input  wire                         pixel_ready,
  output icsb_pkg::pixel_req_t        pixel_req
);
  import icsb_pkg::*;

  logic        prod_valid;
  logic        prod_ready;
  logic        out_ready;
  logic [7:0]  prod_alpha;
  logic [15:0] prod_aa;
  logic [15:0] prod_ta;
  logic [15:0] prod_fill [3];
  logic [15:0] prod_edge [3];

  logic [7:0]  inv_alpha;
  logic [16:0] alpha_sum;
  logic [16:0] chan_sum [3];

  assign out_ready  = !pixel_valid || pixel_ready;
  assign prod_ready = !prod_valid || out_ready;
  assign item_ready = prod_ready;
  assign inv_alpha  = ALPHA_MAX - item.alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid  <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= item_valid;
      end
      if (out_ready) begin
        pixel_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && prod_ready) begin
      prod_alpha <= item.alpha;
      prod_aa    <= item.alpha * item.alpha;
      prod_ta    <= item.shadow * inv_alpha;
      for (int c = 0; c < 3; c++) begin
        prod_fill[c] <= colors.fill_color[8*c +: 8] * item.alpha;
        prod_edge[c] <= colors.edge_color[8*c +: 8] * inv_alpha;
      end
    end
  end

  always_comb begin
    alpha_sum = {1'b0, prod_aa} + {1'b0, prod_ta};
    for (int c = 0; c < 3; c++) begin
      chan_sum[c] = {1'b0, prod_fill[c]} + {1'b0, prod_edge[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && out_ready) begin
      pixel_req.normal_pixel           <= {prod_alpha, colors.text_color};
      pixel_req.disabled_pixel[31:24]  <= alpha_sum[15:8];
      for (int c = 0; c < 3; c++) begin
        pixel_req.disabled_pixel[8*c +: 8] <= chan_sum[c][15:8];
      end
    end
  end

  // A fully opaque pixel ignores the shadow: 255*255/256 rounds down to 254.
  a_opaque_alpha: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_req.normal_pixel[31:24] == ALPHA_MAX |->
      pixel_req.disabled_pixel[31:24] == 8'hFE)
    else $error("opaque pixel has wrong disabled alpha");

endmodule
`default_nettype wire

FILE: sv/icon_shadow_disabled_blend_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icon_shadow_disabled_blend_core
// Turns a raster stream of icon alphas into normal and disabled ARGB pixels.
// ----------------------------------------------------------------------------
// The core takes one pixel request per cycle while the output side does not
// stall. A request passes three register stages (line store, products, sums)
// before its result is presented; stalls on the output side hold the
// pipeline without loss. The rate is set by the previous-row line store,
// which is read and written once per pixel at the current column. Row width
// is clamped to 1..32 pixels, and a request with start_of_image restarts the
// raster at row 0, column 0.
// Write the color and width registers only while no request is in flight.
module icon_shadow_disabled_blend_core (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         alpha_valid,
  output logic                        alpha_ready,
  input  wire  icsb_pkg::alpha_req_t  alpha_req,
  output logic                        pixel_valid,
  input  wire                         pixel_ready,
  output icsb_pkg::pixel_req_t        pixel_req,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [3:0]                  paddr,
  input  wire  [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import icsb_pkg::*;

  logic [5:0]   row_width;
  color_cfg_t   colors;
  reg_idx_t     reg_idx;
  logic         reg_write;

  logic         item_valid;
  logic         item_ready;
  raster_item_t item;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width         <= ROW_WIDTH_RST;
      colors.text_color <= TEXT_COLOR_RST;
      colors.fill_color <= FILL_COLOR_RST;
      colors.edge_color <= EDGE_COLOR_RST;
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_ROW_WIDTH:  row_width         <= pwdata[5:0];
        REG_TEXT_COLOR: colors.text_color <= pwdata[23:0];
        REG_FILL_COLOR: colors.fill_color <= pwdata[23:0];
        REG_EDGE_COLOR: colors.edge_color <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_WIDTH:  prdata = {26'd0, row_width};
      REG_TEXT_COLOR: prdata = {8'd0, colors.text_color};
      REG_FILL_COLOR: prdata = {8'd0, colors.fill_color};
      REG_EDGE_COLOR: prdata = {8'd0, colors.edge_color};
      default:        prdata = '0;
    endcase
  end

  icsb_raster u_raster (
    .clk         (clk),
    .rst         (rst),
    .row_width   (row_width),
    .alpha_valid (alpha_valid),
    .alpha_ready (alpha_ready),
    .alpha_req   (alpha_req),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item)
  );

  icsb_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .colors      (colors),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_req   (pixel_req)
  );

endmodule
`default_nettype wire

FILE: tb/icsb_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icsb_tb_pkg
// The pixel scoreboard for the icon shadow blend bench.
// The scoreboard keeps its own copy of the registers, the previous-row alphas
// and the raster position. It works out both output pixels for every
// accepted alpha request and checks results in order against them.
// ----------------------------------------------------------------------------
package icsb_tb_pkg;
  import icsb_pkg::*;

  class shadow_blend_scoreboard;
    logic [5:0]  row_width;
    logic [23:0] text_color;
    logic [23:0] fill_color;
    logic [23:0] edge_color;
    logic [7:0]  line_alpha [MAX_WIDTH];
    int unsigned column;
    bit          past_first_row;
    logic [7:0]  corner;
    pixel_req_t  expected_pixels [$];
    int          errors;
    int          checked;

    function new();
      row_width      = ROW_WIDTH_RST;
      text_color     = TEXT_COLOR_RST;
      fill_color     = FILL_COLOR_RST;
      edge_color     = EDGE_COLOR_RST;
      foreach (line_alpha[i]) line_alpha[i] = 8'd0;
      column         = 0;
      past_first_row = 1'b0;
      corner         = 8'd0;
      errors         = 0;
      checked        = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_ROW_WIDTH:  row_width  = value[5:0];
        REG_TEXT_COLOR: text_color = value[23:0];
        REG_FILL_COLOR: fill_color = value[23:0];
        REG_EDGE_COLOR: edge_color = value[23:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] mix_channel(int unsigned body, int unsigned rim, int unsigned a);
      return 8'((body * a + rim * (255 - a)) >> 8);
    endfunction

    // Advances the raster position and queues the pixel pair this alpha yields.
    function void note_alpha(alpha_req_t req);
      int unsigned a;
      int unsigned span;
      int unsigned col;
      int unsigned shadow;
      int unsigned mixed_alpha;
      pixel_req_t  px;
      a    = req.alpha_in;
      span = row_width;
      if (span < 1) span = 1;
      if (span > MAX_WIDTH) span = MAX_WIDTH;
      if (req.start_of_image) begin
        column         = 0;
        past_first_row = 1'b0;
      end
      col = (column >= MAX_WIDTH) ? 0 : column;
      // The shadow is the pixel up and to the left, read one column earlier.
      shadow = (col != 0 && past_first_row) ? corner : 0;
      corner = line_alpha[col];
      line_alpha[col] = req.alpha_in;
      if (col + 1 >= span) begin
        column         = 0;
        past_first_row = 1'b1;
      end else begin
        column = col + 1;
      end
      mixed_alpha = (a * a + shadow * (255 - a)) >> 8;
      px.normal_pixel   = {req.alpha_in, text_color};
      px.disabled_pixel = {8'(mixed_alpha),
                           mix_channel(fill_color[23:16], edge_color[23:16], a),
                           mix_channel(fill_color[15:8], edge_color[15:8], a),
                           mix_channel(fill_color[7:0], edge_color[7:0], a)};
      expected_pixels.push_back(px);
    endfunction

    function void check_pixel(pixel_req_t got);
      pixel_req_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel result with no request pending: %h", $time, got);
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got.normal_pixel !== want.normal_pixel) begin
        errors++;
        $display("%0t: normal_pixel expected %h, got %h", $time, want.normal_pixel,
                 got.normal_pixel);
      end
      if (got.disabled_pixel !== want.disabled_pixel) begin
        errors++;
        $display("%0t: disabled_pixel expected %h, got %h", $time, want.disabled_pixel,
                 got.disabled_pixel);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the icon shadow disabled blend core.
// Alpha requests go in raster order under several register settings, with
// random gaps on the input and random stalls on the output. Every result is
// compared against the scoreboard's pixel pair for the matching request.
// ----------------------------------------------------------------------------
module tb;
  import icsb_pkg::*;
  import icsb_tb_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_PIXELS = 55;

  logic        clk = 1'b0;
  logic        rst;
  logic        alpha_valid;
  logic        alpha_ready;
  alpha_req_t  alpha_req;
  logic        pixel_valid;
  logic        pixel_ready;
  pixel_req_t  pixel_req;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  shadow_blend_scoreboard blend_sb;
  bit steady;
  int pixels_sent;
  int settings_used;
  int idle_cycles;

  icon_shadow_disabled_blend_core dut (
    .clk         (clk),
    .rst         (rst),
    .alpha_valid (alpha_valid),
    .alpha_ready (alpha_ready),
    .alpha_req   (alpha_req),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_req   (pixel_req),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && pixel_valid && pixel_ready) blend_sb.check_pixel(pixel_req);
  end

  always @(posedge clk) begin
    if ((alpha_valid && alpha_ready) || (pixel_valid && pixel_ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : pixel_sink
    int stall;
    pixel_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        pixel_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pixel_ready <= 1'b1;
      do @(posedge clk); while (pixel_valid !== 1'b1);
    end
  end

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_color();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Leaves psel high so that back-to-back writes need no release in between.
  task automatic csr_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    blend_sb.set_register(idx, value);
  endtask

  task automatic apply_setting(input logic [5:0] width, input logic [23:0] text,
                               input logic [23:0] fill, input logic [23:0] rim);
    csr_write(REG_ROW_WIDTH, 32'(width));
    csr_write(REG_TEXT_COLOR, 32'(text));
    csr_write(REG_FILL_COLOR, 32'(fill));
    csr_write(REG_EDGE_COLOR, 32'(rim));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(input logic [7:0] a, input logic sof);
    int         gap;
    alpha_req_t req;
    gap = steady ? 0 : $urandom_range(0, 10);
    req.alpha_in       = a;
    req.start_of_image = sof;
    if (gap > 0) begin
      alpha_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    alpha_valid <= 1'b1;
    alpha_req   <= req;
    do @(posedge clk); while (alpha_ready !== 1'b1);
    blend_sb.note_alpha(req);
    pixels_sent++;
  endtask

  task automatic drain();
    alpha_valid <= 1'b0;
    while (blend_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [5:0] width;
    int         span;
    int         len;
    int         kind;
    int         sent_in_phase;
    logic       sof;
    rst           = 1'b1;
    alpha_valid   = 1'b0;
    alpha_req     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    steady        = 1'b0;
    pixels_sent   = 0;
    settings_used = 0;
    idle_cycles   = 0;
    blend_sb      = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings and no start marker: the image begins at reset. One row
    // of 16 and two pixels of the next row go in.
    for (int i = 0; i < 18; i++) send_pixel(i[0] ? 8'hFF : 8'(i * 29), 1'b0);
    drain();
    apply_setting(6'd8, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
    for (int i = 0; i < 10; i++) send_pixel(i[0] ? 8'h00 : 8'hFF - 8'(i), i == 0);
    drain();
    // The column now sits past the new, narrower row.
    apply_setting(6'd2, 24'h000000, 24'hFFFFFF, 24'h000000);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h01, 1'b0);
    drain();

    // A full-width image first, so every line store entry holds a real alpha
    // before later settings can widen the row.
    apply_setting(6'd32, pick_color(), pick_color(), pick_color());
    for (int i = 0; i < 3 * MAX_WIDTH; i++) send_pixel(pick_alpha(), i == 0);

    for (int phase = 1; phase < 12; phase++) begin
      drain();
      case (phase)
        1: width = 6'd0;
        2: width = 6'd63;
        3: width = 6'd1;
        default: begin
          case ($urandom_range(0, 4))
            0: width = 6'd32;
            1: width = 6'd2;
            2: width = 6'($urandom_range(33, 63));
            default: width = 6'($urandom_range(1, 31));
          endcase
        end
      endcase
      span = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
      apply_setting(width, pick_color(), pick_color(), pick_color());
      steady = (phase % 4 == 3);
      sent_in_phase = 0;
      while (sent_in_phase < PHASE_PIXELS) begin
        // Mostly whole images; some cut short, some resumed without a start
        // marker, and some with start markers scattered at random.
        kind = $urandom_range(0, 9);
        len  = (kind < 7) ? span * $urandom_range(1, 4) : $urandom_range(1, 2 * span + 3);
        for (int i = 0; i < len; i++) begin
          sof = (i == 0) && (kind != 8);
          if (kind == 9) sof = ($urandom_range(0, 7) == 0);
          send_pixel(pick_alpha(), sof);
        end
        sent_in_phase += len;
      end
    end
    steady = 1'b0;
    drain();

    $display("Covered %0d pixel requests under %0d register settings, %0d results checked,",
             pixels_sent, settings_used, blend_sb.checked);
    $display("with row widths 0, 1, 2, 32 and above 32, and random gaps on both sides.");
    if (blend_sb.errors == 0 && blend_sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/icsb_pkg.sv
sv/icsb_raster.sv
sv/icsb_blend.sv
sv/icon_shadow_disabled_blend_core.sv
tb/icsb_tb_pkg.sv
tb/tb.sv
